// File: sv/triangle_tangent_basis_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent basis core
// Wraps concurrent assertions so that synthesis builds see none of them.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BASIS_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define TTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every edge, also during reset.
`define TTB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define TTB_ASSERT(lbl, prop)
`define TTB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared widths, constants and types of the triangle tangent basis core.
// ----------------------------------------------------------------------------
`default_nettype none
package ttb_pkg;
    localparam int CoordW = 32;
    localparam int DeltaW = CoordW + 1;
    localparam int ProdW  = 2 * DeltaW;
    localparam int AccW   = ProdW + 1;
    localparam int MagW   = ProdW;
    localparam int NormW  = 31;
    localparam int SumW   = 64;
    localparam int OutW   = 32;
    localparam logic [OutW-1:0] OneQ30 = 32'h4000_0000;

    // Edge and texture deltas of one triangle, relative to its first vertex.
    typedef struct packed {
        logic [2:0][DeltaW-1:0] e1;
        logic [2:0][DeltaW-1:0] e2;
        logic [DeltaW-1:0]      du1;
        logic [DeltaW-1:0]      dv1;
        logic [DeltaW-1:0]      du2;
        logic [DeltaW-1:0]      dv2;
    } tri_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;
endpackage
`default_nettype wire

// File: sv/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front
// Gathers vertices into triangles and forms the deltas on the third vertex.
// ----------------------------------------------------------------------------
`default_nettype none
module ttb_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [159:0]         s_tdata,
    input  wire ttb_pkg::fifo_stat_t  stat,
    output logic                      push,
    output ttb_pkg::tri_t             tri_item
);
    import ttb_pkg::*;

    logic [1:0]                   slot_reg;
    logic [1:0][2:0][CoordW-1:0]  pos_reg;
    logic [1:0][1:0][CoordW-1:0]  tex_reg;
    logic [2:0][CoordW-1:0]       in_pos;
    logic [1:0][CoordW-1:0]       in_tex;
    logic                         accept;

    assign in_pos[0] = s_tdata[31:0];
    assign in_pos[1] = s_tdata[63:32];
    assign in_pos[2] = s_tdata[95:64];
    assign in_tex[0] = s_tdata[127:96];
    assign in_tex[1] = s_tdata[159:128];

    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (slot_reg == 2'd2);

    function automatic logic [DeltaW-1:0] sub33(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
        sub33 = {a[CoordW-1], a} - {b[CoordW-1], b};
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tri_item.e1[k] = sub33(pos_reg[1][k], pos_reg[0][k]);
            tri_item.e2[k] = sub33(in_pos[k], pos_reg[0][k]);
        end
        tri_item.du1 = sub33(tex_reg[1][0], tex_reg[0][0]);
        tri_item.dv1 = sub33(tex_reg[1][1], tex_reg[0][1]);
        tri_item.du2 = sub33(in_tex[0], tex_reg[0][0]);
        tri_item.dv2 = sub33(in_tex[1], tex_reg[0][1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
        end
        else if (accept)
        begin
            unique case (slot_reg)
                2'd1:
                begin
                    pos_reg[1] <= in_pos;
                    tex_reg[1] <= in_tex;
                    slot_reg   <= 2'd2;
                end
                2'd2:
                begin
                    slot_reg <= 2'd0;
                end
                default:
                begin
                    // Slot 0 and the unused slot code 3 both start a new triangle.
                    pos_reg[0] <= in_pos;
                    tex_reg[0] <= in_tex;
                    slot_reg   <= 2'd1;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/ttb_fifo.sv
// ----------------------------------------------------------------------------
// ttb_fifo
// Two-entry queue of triangles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module ttb_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ttb_pkg::tri_t        din,
    input  wire logic                 pop,
    output ttb_pkg::tri_t             dout,
    output ttb_pkg::fifo_stat_t       stat
);
    import ttb_pkg::*;

    tri_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= din;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: sv/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back
// Sequencer that computes and normalizes tangent and binormal of a triangle
// with one shared multiplier, a bit-serial square root and a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ttb_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ttb_pkg::tri_t        tri_item,
    input  wire ttb_pkg::fifo_stat_t  stat,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [191:0]              m_tdata,
    output logic [0:0]                m_tuser
);
    import ttb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_NLOAD, S_SHIFT, S_SQMUL, S_SQACC,
        S_SQRT, S_DLOAD, S_DIV, S_OUT
    } state_t;

    state_t                      state_reg;
    tri_t                        item_reg;
    logic [3:0]                  step_reg;
    logic signed [ProdW-1:0]     prod_reg;
    logic signed [AccW-1:0]      acc_reg;
    logic                        detneg_reg;
    logic                        degen_reg;
    logic [1:0][2:0]             neg_reg;
    logic [1:0][2:0][MagW-1:0]   mag_reg;
    logic                        vsel_reg;
    logic [2:0][MagW-1:0]        sh_reg;
    logic [1:0]                  k_reg;
    logic [SumW-1:0]             s_reg;
    logic [SumW-1:0]             x_reg;
    logic [SumW-1:0]             r_reg;
    logic [SumW-1:0]             bit_reg;
    logic [32:0]                 rem_reg;
    logic [31:0]                 num_reg;
    logic [31:0]                 q_reg;
    logic [4:0]                  cnt_reg;
    logic [1:0][2:0][OutW-1:0]   res_reg;
    logic                        out_valid_reg;
    logic [191:0]                out_data_reg;
    logic                        out_degen_reg;

    logic signed [DeltaW-1:0]    op_a;
    logic signed [DeltaW-1:0]    op_b;
    logic signed [ProdW-1:0]     prod_next;
    logic [3:0]                  j;
    logic [1:0]                  jk;
    logic signed [AccW-1:0]      diff_next;
    logic signed [AccW-1:0]      vec_next;
    logic [NormW-1:0]            m_sel;
    logic [SumW-1:0]             sum_next;
    logic [SumW-1:0]             trial;
    logic [61:0]                 n_next;
    logic [33:0]                 rem2;
    logic                        ge;
    logic [31:0]                 q_fin;
    logic [31:0]                 q_clamp;

    assign j    = step_reg - 4'd2;
    assign jk   = j[3:2];
    assign m_sel = sh_reg[k_reg][MagW-1 -: NormW];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == S_SQMUL)
        begin
            op_a = $signed({2'b00, m_sel});
            op_b = $signed({2'b00, m_sel});
        end
        else if (step_reg == 4'd0)
        begin
            op_a = $signed(item_reg.du1);
            op_b = $signed(item_reg.dv2);
        end
        else if (step_reg == 4'd1)
        begin
            op_a = $signed(item_reg.du2);
            op_b = $signed(item_reg.dv1);
        end
        else
        begin
            unique case ({j[1], j[0]})
                2'b00:
                begin
                    op_a = $signed(item_reg.dv2);
                    op_b = $signed(item_reg.e1[jk]);
                end
                2'b01:
                begin
                    op_a = $signed(item_reg.dv1);
                    op_b = $signed(item_reg.e2[jk]);
                end
                2'b10:
                begin
                    op_a = $signed(item_reg.du1);
                    op_b = $signed(item_reg.e2[jk]);
                end
                default:
                begin
                    op_a = $signed(item_reg.du2);
                    op_b = $signed(item_reg.e1[jk]);
                end
            endcase
        end
    end

    assign prod_next = op_a * op_b;
    assign diff_next = acc_reg - AccW'(prod_reg);
    assign vec_next  = detneg_reg ? -diff_next : diff_next;
    assign sum_next  = s_reg + prod_reg[SumW-1:0];
    assign trial     = r_reg + bit_reg;
    assign n_next    = {m_sel, 30'd0} + 62'(r_reg[SumW-1:1]);
    assign rem2      = {rem_reg, num_reg[31]};
    assign ge        = rem2 >= {1'b0, r_reg[32:0]};
    assign q_fin     = {q_reg[30:0], ge};
    assign q_clamp   = (q_fin > OneQ30) ? OneQ30 : q_fin;

    assign pop      = (state_reg == S_IDLE) && !stat.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output register loads in S_OUT and empties on a transfer.
            if (state_reg == S_OUT)
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!stat.empty)
                    begin
                        item_reg  <= tri_item;
                        step_reg  <= 4'd0;
                        degen_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (!step_reg[0])
                    begin
                        acc_reg   <= AccW'(prod_reg);
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                    else if (step_reg == 4'd1)
                    begin
                        if (diff_next == '0)
                        begin
                            // A zero determinant gives no basis at all.
                            degen_reg <= 1'b1;
                            res_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            detneg_reg <= diff_next < 0;
                            step_reg   <= 4'd2;
                            state_reg  <= S_MUL;
                        end
                    end
                    else
                    begin
                        neg_reg[j[1]][jk] <= vec_next < 0;
                        mag_reg[j[1]][jk] <= (vec_next < 0) ? MagW'(-vec_next)
                                                             : MagW'(vec_next);
                        if (step_reg == 4'd13)
                        begin
                            vsel_reg  <= 1'b0;
                            state_reg <= S_NLOAD;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_NLOAD:
                begin
                    sh_reg <= mag_reg[vsel_reg];
                    if (mag_reg[vsel_reg] == '0)
                    begin
                        degen_reg         <= 1'b1;
                        res_reg[vsel_reg] <= '0;
                        vsel_reg          <= 1'b1;
                        state_reg         <= vsel_reg ? S_OUT : S_NLOAD;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    // Bring the largest magnitude to the top bit; the upper 31 bits
                    // are then the scaled components.
                    if (sh_reg[0][MagW-1] || sh_reg[1][MagW-1] || sh_reg[2][MagW-1])
                    begin
                        k_reg     <= 2'd0;
                        s_reg     <= '0;
                        state_reg <= S_SQMUL;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            sh_reg[k] <= {sh_reg[k][MagW-2:0], 1'b0};
                        end
                    end
                end
                S_SQMUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SQACC;
                end
                S_SQACC:
                begin
                    s_reg <= sum_next;
                    if (k_reg == 2'd2)
                    begin
                        x_reg     <= sum_next;
                        r_reg     <= '0;
                        bit_reg   <= SumW'(1) << (SumW - 2);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_SQMUL;
                    end
                end
                S_SQRT:
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg <= x_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= S_DLOAD;
                    end
                end
                S_DLOAD:
                begin
                    rem_reg   <= {3'd0, n_next[61:32]};
                    num_reg   <= n_next[31:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= ge ? 33'(rem2 - {1'b0, r_reg[32:0]}) : rem2[32:0];
                    num_reg <= {num_reg[30:0], 1'b0};
                    q_reg   <= q_fin;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        res_reg[vsel_reg][k_reg] <= neg_reg[vsel_reg][k_reg] ? -q_clamp
                                                                             : q_clamp;
                        if (k_reg == 2'd2)
                        begin
                            vsel_reg  <= 1'b1;
                            state_reg <= vsel_reg ? S_OUT : S_NLOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_DLOAD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= res_reg;
                        out_degen_reg <= degen_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/triangle_tangent_basis_core.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis core.
// Input stream s_*: one vertex per transfer (position and texture coordinate,
// Q16.16). Every third vertex closes a triangle; the first two give no result.
// Output stream m_*: one transfer per triangle with the unit tangent and binormal
// in Q2.30 and a degenerate flag in m_tuser.
// A front stage gathers vertices and forms the deltas; a two-entry triangle
// queue separates it from the back sequencer. Vertices are taken one per cycle
// until the queue holds two triangles.
// The back handles one triangle at a time: products on one shared multiplier,
// then per vector leading-bit alignment, squares, a bit-serial square root
// and a serial division for each of the three components. A zero determinant
// goes straight to the output with the degenerate flag and zero vectors.
// Reset clears the vertex slot, the queue and the output valid.
// While the receiver stalls, the result waits in the output register; the back
// may finish the next triangle and then waits, and the front keeps filling
// the queue until it holds two triangles.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_tangent_basis_core_macros.svh"
module triangle_tangent_basis_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each, from bit 0 up)
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [191:0]      m_tdata,
    // degenerate
    output logic [0:0]        m_tuser
);
    import ttb_pkg::*;

    fifo_stat_t stat;
    tri_t       front_item;
    tri_t       back_item;
    logic       push;
    logic       pop;

    ttb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .push     (push),
        .tri_item (front_item)
    );

    ttb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .pop   (pop),
        .dout  (back_item),
        .stat  (stat)
    );

    ttb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .tri_item (back_item),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `TTB_ASSERT(a_no_overflow, push |-> !stat.full)
    `TTB_ASSERT(a_no_underflow, pop |-> !stat.empty)
    // The tangent x word lies within minus one and plus one.
    `TTB_ASSERT(a_unit_range, m_tvalid |-> 32'(m_tdata[31:0] + OneQ30) <= 32'h8000_0000)
    `TTB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid || !$past(rst_n))
endmodule
`default_nettype wire
